>>> design/mi3_pkg.sv
// Package for the 3x3 matrix inverse: shared widths, pipeline depths, saturation codes and
// the per-lane flag type.
// Used by every module of the block; depends on nothing.
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int N_ELEM         = 9;
  localparam int RES_W          = 32;
  localparam int QUO_BITS       = 32;
  localparam int FRONT_ST       = 4;
  localparam int LANE_ST        = QUO_BITS + 2;
  localparam int N_ST           = FRONT_ST + LANE_ST + 1;
  localparam int OUT_W          = N_ELEM * RES_W;
  localparam int USER_W         = 2;

  localparam logic [RES_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic overflowed;
    logic singular;
  } lane_flags_t;

endpackage

>>> design/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse by the adjugate, Q8.8 in, Q16.16 out.
// Depends on mi3_pkg, mi3_front, mi3_lane and mi3_merge.
//
//   Channel  | Direction | Beat carries
//   in_      | input     | one matrix, nine signed elements, row-major
//   out_     | output    | nine inverse elements plus singular and overflow flags
//
// One matrix is taken per clock while the output is not stalled. The pipeline has four
// cofactor and determinant stages, nine parallel divider lanes of 34 stages and one
// output stage. The 32 restoring-division stages of each lane set the depth.
// Reset clears only the stage valid bits. A stalled output holds its beat; earlier stages
// keep filling until every stage behind it is occupied.
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // elem_r0c0, elem_r0c1, ... elem_r2c2, ELEM_WIDTH bits each, zero padded to bytes
  input  logic [((N_ELEM*ELEM_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // inv_r0c0, inv_r0c1, ... inv_r2c2, 32 bits each
  output logic [OUT_W-1:0]                      out_tdata,
  // singular, overflowed
  output logic [USER_W-1:0]                     out_tuser
);

  localparam int AW  = 2 * ELEM_WIDTH + 1;
  localparam int DTW = 3 * ELEM_WIDTH + 3;

  logic [N_ST-1:0] v_r;
  logic [N_ST-1:0] v_nxt;
  logic [N_ST-1:0] en;

  logic [N_ELEM*AW-1:0]   adj;
  logic signed [DTW-1:0]  det;
  logic [OUT_W-1:0]       res;
  lane_flags_t            flags [N_ELEM];

  // A stage loads when it is empty or the stage after it loads too.
  assign en[N_ST-1] = !v_r[N_ST-1] || out_tready;
  genvar gs;
  generate
    for (gs = 0; gs < N_ST - 1; gs++) begin : g_en
      assign en[gs] = !v_r[gs] || en[gs+1];
    end
  endgenerate

  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_tvalid;
    for (int s = 1; s < N_ST; s++) begin
      if (en[s]) v_nxt[s] = v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[N_ST-1];

  mi3_front #(.EW(ELEM_WIDTH)) u_front (
    .clk   (clk),
    .en    (en[FRONT_ST-1:0]),
    .elems (in_tdata[N_ELEM*ELEM_WIDTH-1:0]),
    .adj_o (adj),
    .det_o (det)
  );

  genvar gl;
  generate
    for (gl = 0; gl < N_ELEM; gl++) begin : g_lane
      mi3_lane #(.EW(ELEM_WIDTH), .FB(FRAC_BITS)) u_lane (
        .clk   (clk),
        .en    (en[FRONT_ST +: LANE_ST]),
        .adj   (adj[gl*AW +: AW]),
        .det   (det),
        .res   (res[gl*RES_W +: RES_W]),
        .flags (flags[gl])
      );
    end
  endgenerate

  mi3_merge u_merge (
    .clk   (clk),
    .en    (en[N_ST-1]),
    .res   (res),
    .flags (flags),
    .tdata (out_tdata),
    .tuser (out_tuser)
  );

endmodule

>>> design/mi3_front.sv
// Front end of the 3x3 matrix inverse: cofactor products, adjugate and determinant.
// Four pipeline stages, each held while its enable is low. Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; #(
  parameter int EW = ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic [FRONT_ST-1:0]           en,
  input  logic [N_ELEM*EW-1:0]          elems,
  output logic [N_ELEM*(2*EW+1)-1:0]    adj_o,
  output logic signed [3*EW+2:0]        det_o
);

  localparam int MW  = 2 * EW;
  localparam int AW  = 2 * EW + 1;
  localparam int DTW = 3 * EW + 3;
  localparam int PW  = EW + AW;

  logic signed [EW-1:0]   a      [N_ELEM];
  logic signed [2*EW-1:0] pa_r   [N_ELEM];
  logic signed [2*EW-1:0] pb_r   [N_ELEM];
  logic signed [EW-1:0]   row0_r [3];
  logic signed [EW-1:0]   row1_r [3];
  logic signed [AW-1:0]   adj1_r [N_ELEM];
  logic signed [AW-1:0]   adj2_r [N_ELEM];
  logic signed [AW-1:0]   adj3_r [N_ELEM];
  logic signed [PW-1:0]   dp_r   [3];
  logic signed [DTW-1:0]  det_r;

  genvar gi, gj;
  generate
    for (gi = 0; gi < N_ELEM; gi++) begin : g_unpack
      assign a[gi] = elems[gi*EW +: EW];
      assign adj_o[gi*AW +: AW] = adj3_r[gi];
    end

    // Cofactor of the transposed position gives the adjugate directly.
    for (gi = 0; gi < 3; gi++) begin : g_row
      for (gj = 0; gj < 3; gj++) begin : g_col
        localparam int I1 = (gi + 1) % 3;
        localparam int I2 = (gi + 2) % 3;
        localparam int J1 = (gj + 1) % 3;
        localparam int J2 = (gj + 2) % 3;
        localparam int IX = gi * 3 + gj;
        always_ff @(posedge clk) begin
          if (en[0]) begin
            pa_r[IX] <= MW'(a[J1*3+I1]) * MW'(a[J2*3+I2]);
            pb_r[IX] <= MW'(a[J1*3+I2]) * MW'(a[J2*3+I1]);
          end
          if (en[1]) adj1_r[IX] <= AW'(pa_r[IX]) - AW'(pb_r[IX]);
          if (en[2]) adj2_r[IX] <= adj1_r[IX];
          if (en[3]) adj3_r[IX] <= adj2_r[IX];
        end
      end
    end

    for (gi = 0; gi < 3; gi++) begin : g_det
      always_ff @(posedge clk) begin
        if (en[0]) row0_r[gi] <= a[gi];
        if (en[1]) row1_r[gi] <= row0_r[gi];
        if (en[2]) dp_r[gi]   <= PW'(row1_r[gi]) * PW'(adj1_r[gi*3]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[3]) det_r <= DTW'(dp_r[0]) + DTW'(dp_r[1]) + DTW'(dp_r[2]);
  end

  assign det_o = det_r;

endmodule

>>> design/mi3_lane.sv
// One lane of the 3x3 matrix inverse: signed division of one adjugate element by the
// determinant, one quotient bit per stage, then saturation. Depends on mi3_pkg.
module mi3_lane import mi3_pkg::*; #(
  parameter int EW = ELEM_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic [LANE_ST-1:0]       en,
  input  logic signed [2*EW:0]     adj,
  input  logic signed [3*EW+2:0]   det,
  output logic [RES_W-1:0]         res,
  output lane_flags_t              flags
);

  localparam int AW  = 2 * EW + 1;
  localparam int DTW = 3 * EW + 3;
  localparam int DM  = DTW;
  localparam int NW  = AW + FB + 16;
  localparam int HW  = NW - QUO_BITS;
  localparam int CW  = (HW > DM) ? HW : DM;

  logic [AW-1:0]   adj_mag;
  logic [DM-1:0]   det_mag;
  logic [NW-1:0]   num;
  logic [CW-1:0]   hi_ext;

  logic [DM-1:0]       rem_r  [QUO_BITS+1];
  logic [QUO_BITS-1:0] lo_r   [QUO_BITS+1];
  logic [QUO_BITS-1:0] q_r    [QUO_BITS+1];
  logic [DM-1:0]       d_r    [QUO_BITS+1];
  logic                neg_r  [QUO_BITS+1];
  logic                zero_r [QUO_BITS+1];
  logic                ovh_r  [QUO_BITS+1];

  logic [RES_W-1:0] res_r;
  lane_flags_t      flags_r;
  logic [RES_W-1:0] res_nxt;
  lane_flags_t      flags_nxt;
  logic [QUO_BITS-1:0] qf;

  assign adj_mag = adj[AW-1] ? AW'(-adj) : AW'(adj);
  assign det_mag = det[DTW-1] ? DM'(-det) : DM'(det);
  assign num     = {adj_mag, {(FB+16){1'b0}}};
  assign hi_ext  = CW'(num[NW-1:QUO_BITS]);

  // The quotient reaches 2^32 exactly when the upper part alone is not below the divisor.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= hi_ext[DM-1:0];
      lo_r[0]   <= num[QUO_BITS-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= det_mag;
      neg_r[0]  <= adj[AW-1] ^ det[DTW-1];
      zero_r[0] <= (det == '0);
      ovh_r[0]  <= (hi_ext >= CW'(det_mag));
    end
  end

  genvar gs;
  generate
    for (gs = 1; gs <= QUO_BITS; gs++) begin : g_step
      logic [DM:0] trial;
      logic [DM:0] diff;
      logic        ge;
      assign trial = {rem_r[gs-1], lo_r[gs-1][QUO_BITS-1]};
      assign diff  = trial - {1'b0, d_r[gs-1]};
      assign ge    = (trial >= {1'b0, d_r[gs-1]});
      always_ff @(posedge clk) begin
        if (en[gs]) begin
          rem_r[gs]  <= ge ? diff[DM-1:0] : trial[DM-1:0];
          lo_r[gs]   <= {lo_r[gs-1][QUO_BITS-2:0], 1'b0};
          q_r[gs]    <= {q_r[gs-1][QUO_BITS-2:0], ge};
          d_r[gs]    <= d_r[gs-1];
          neg_r[gs]  <= neg_r[gs-1];
          zero_r[gs] <= zero_r[gs-1];
          ovh_r[gs]  <= ovh_r[gs-1];
        end
      end
    end
  endgenerate

  assign qf = q_r[QUO_BITS];

  always_comb begin
    flags_nxt.singular   = zero_r[QUO_BITS];
    flags_nxt.overflowed = 1'b0;
    if (zero_r[QUO_BITS]) begin
      res_nxt = '0;
    end else if (ovh_r[QUO_BITS]) begin
      res_nxt = neg_r[QUO_BITS] ? SAT_NEG : SAT_POS;
      flags_nxt.overflowed = 1'b1;
    end else if (!neg_r[QUO_BITS] && (qf > SAT_POS)) begin
      res_nxt = SAT_POS;
      flags_nxt.overflowed = 1'b1;
    end else if (neg_r[QUO_BITS] && (qf > SAT_NEG)) begin
      res_nxt = SAT_NEG;
      flags_nxt.overflowed = 1'b1;
    end else begin
      res_nxt = neg_r[QUO_BITS] ? (RES_W'(0) - qf) : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LANE_ST-1]) begin
      res_r   <= res_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign res   = res_r;
  assign flags = flags_r;

endmodule

>>> design/mi3_merge.sv
// Output stage of the 3x3 matrix inverse: packs the nine lane results into one beat and
// combines the lane flags. Depends on mi3_pkg.
module mi3_merge import mi3_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [OUT_W-1:0]  res,
  input  lane_flags_t       flags [N_ELEM],
  output logic [OUT_W-1:0]  tdata,
  output logic [USER_W-1:0] tuser
);

  logic [OUT_W-1:0]  tdata_r;
  logic [USER_W-1:0] tuser_r;
  logic              ovf_any;

  always_comb begin
    ovf_any = 1'b0;
    for (int i = 0; i < N_ELEM; i++) ovf_any = ovf_any | flags[i].overflowed;
  end

  // Every lane sees the same determinant, so any one of them reports a singular matrix.
  always_ff @(posedge clk) begin
    if (en) begin
      tdata_r <= res;
      tuser_r <= {ovf_any, flags[0].singular};
    end
  end

  assign tdata = tdata_r;
  assign tuser = tuser_r;

endmodule

>>> sim/tb.sv
// Testbench for matrix3x3_inverse: random and directed Q8.8 matrices on the input stream,
// inverse elements and flags checked against a fixed-point adjugate predictor.
// Depends on mi3_pkg and the matrix3x3_inverse RTL.
module tb import mi3_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = ((N_ELEM * ELEM_WIDTH_DEF + 7) / 8) * 8;
  localparam int N_RANDOM = 1300;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [RES_W-1:0] inv [N_ELEM];
    logic             singular;
    logic             overflowed;
  } inverse_t;

  // Holds the expected inverses in order and compares each output beat with the oldest.
  class inverse_scoreboard;
    inverse_t pending[$];
    int       errors;

    function inverse_t predict(logic [IN_W-1:0] data);
      inverse_t r;
      logic signed [127:0] a [3][3];
      logic signed [127:0] adj [3][3];
      logic signed [127:0] det, num, mdet;
      logic [127:0] q;
      logic neg;
      int i1, i2, j1, j2;
      for (int k = 0; k < N_ELEM; k++)
        a[k / 3][k % 3] = 128'(signed'(data[k*ELEM_WIDTH_DEF +: ELEM_WIDTH_DEF]));
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          i1 = (i + 1) % 3; i2 = (i + 2) % 3; j1 = (j + 1) % 3; j2 = (j + 2) % 3;
          adj[i][j] = a[j1][i1] * a[j2][i2] - a[j1][i2] * a[j2][i1];
        end
      det = a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0];
      r.singular = (det == 0);
      r.overflowed = 1'b0;
      for (int k = 0; k < N_ELEM; k++) r.inv[k] = '0;
      if (r.singular) return r;
      mdet = det < 0 ? -det : det;
      for (int k = 0; k < N_ELEM; k++) begin
        num = adj[k / 3][k % 3] <<< (FRAC_BITS_DEF + 16);
        neg = (num < 0) != (det < 0);
        if (num < 0) num = -num;
        q = 128'(num) / 128'(mdet);
        if (q == 0) neg = 1'b0;
        if (!neg && q > 128'h7FFF_FFFF) begin
          r.inv[k] = SAT_POS; r.overflowed = 1'b1;
        end else if (neg && q > 128'h8000_0000) begin
          r.inv[k] = SAT_NEG; r.overflowed = 1'b1;
        end else begin
          r.inv[k] = neg ? 32'(-q) : q[31:0];
        end
      end
      return r;
    endfunction

    function void note_matrix(logic [IN_W-1:0] data);
      pending.push_back(predict(data));
    endfunction

    function void check_inverse(logic [OUT_W-1:0] data, logic [USER_W-1:0] user);
      inverse_t e;
      if (pending.size() == 0) begin
        $error("output beat with no matrix outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < N_ELEM; k++)
        if (data[k*RES_W +: RES_W] !== e.inv[k]) begin
          $error("inv_r%0dc%0d expected %h actual %h", k / 3, k % 3, e.inv[k],
                 data[k*RES_W +: RES_W]);
          errors++;
        end
      if (user[0] !== e.singular) begin
        $error("singular expected %b actual %b", e.singular, user[0]);
        errors++;
      end
      if (user[1] !== e.overflowed) begin
        $error("overflowed expected %b actual %b", e.overflowed, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;

  inverse_scoreboard sb = new();
  bit quiet_tail = 1'b0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  matrix3x3_inverse u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_matrix(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_inverse(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[matrix3x3_inverse] ERROR");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except during the quiet tail.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (quiet_tail || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_matrix(logic [IN_W-1:0] data);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_matrix(logic [15:0] e [N_ELEM]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int k = 0; k < N_ELEM; k++) d[k*ELEM_WIDTH_DEF +: ELEM_WIDTH_DEF] = e[k];
    return d;
  endfunction

  function automatic logic [15:0] random_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      3: return $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] m [N_ELEM];
    int kind;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: identity, zero, extremes, singular rows, tiny determinant.
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'h0100 : 16'h0000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = 16'h0000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'h8000 : 16'h0000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'h7FFF : 16'h0000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'h0001 : 16'h0000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'hFFFF : 16'h0000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = 16'h8000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = 16'h7FFF;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = 16'hFFFF;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 2) ? 16'h8000 : 16'h7FFF;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = 16'(k * 16'h0100 + 16'h0100);
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'h7FFF : 16'h8000;
    send_matrix(pack_matrix(m));
    foreach (m[k]) m[k] = (k % 4 == 0) ? 16'h0200 : 16'hFF00;
    send_matrix(pack_matrix(m));

    // Hold off until the pipeline has drained completely.
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      foreach (m[k]) m[k] = random_elem();
      if (kind == 0) begin
        // Repeated row gives a singular matrix.
        for (int c = 0; c < 3; c++) m[6 + c] = m[c];
      end else if (kind == 1) begin
        // Diagonal matrix, often with small entries that saturate.
        foreach (m[k]) if (k % 4 != 0) m[k] = 16'h0000;
      end
      if (n >= N_RANDOM - 150) quiet_tail = 1'b1;
      send_matrix(pack_matrix(m));
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (N_ST + 10) @(negedge clk);
    if (sb.errors == 0) $display("[matrix3x3_inverse] OK");
    else $display("[matrix3x3_inverse] ERROR");
    $finish;
  end
endmodule
